// File: src/box_blur_3x3_clipped_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur.
// Shared property forms used by the blur's own checks.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_CLIPPED_DEFINES_SVH
`define BOX_BLUR_3X3_CLIPPED_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bb3_pkg.sv
// ----------------------------------------------------------------------------
// Box blur package
// Widths, register indexes, stage records and the reciprocal table.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int CHAN_BITS   = 8;
   localparam int PIX_BITS    = 3 * CHAN_BITS;
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 12;
   localparam int ROW_BITS    = 13;
   localparam int POS_BITS    = 24;
   localparam int TOTAL_BITS  = 23;
   localparam int SUM_BITS    = 12;
   localparam int CNT_BITS    = 4;
   localparam int RECIP_BITS  = 20;
   localparam int RECIP_SHIFT = 20;
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd480;

   typedef logic [PIX_BITS-1:0] pixel_type;

   typedef struct packed {
      logic      emit;
      logic      up;
      logic      down;
      logic      left;
      logic      right;
      logic      last;
      logic      fwd;
      pixel_type pixel;
      pixel_type fwd_up;
      pixel_type fwd_mid;
   } step_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] red;
      logic [SUM_BITS-1:0] green;
      logic [SUM_BITS-1:0] blue;
      logic [CNT_BITS-1:0] cnt;
      logic                last;
   } sums_type;

   // Rounded-up 2^20 / (2 * count); exact for every sum a window can reach.
   function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
      logic [RECIP_BITS-1:0] m;
      case (cnt)
         4'd1: begin
            m = 20'd524288;
         end
         4'd2: begin
            m = 20'd262144;
         end
         4'd3: begin
            m = 20'd174763;
         end
         4'd4: begin
            m = 20'd131072;
         end
         4'd6: begin
            m = 20'd87382;
         end
         4'd9: begin
            m = 20'd58255;
         end
         default: begin
            m = '0;
         end
      endcase
      return m;
   endfunction

endpackage

// File: src/bb3_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bb3_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bb3_csr.sv
// ----------------------------------------------------------------------------
// Box blur register block
// Image size registers, their clamped values and the pixel count per image.
// ----------------------------------------------------------------------------
module bb3_csr #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bb3_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [bb3_pkg::DATA_BITS-1:0]     pwdata,
   output logic [bb3_pkg::DATA_BITS-1:0]     prdata,
   output logic                              pready,
   output logic                              cfg_wr,
   output logic [bb3_pkg::WIDTH_BITS-1:0]    width_eff,
   output logic [bb3_pkg::HEIGHT_BITS-1:0]   height_eff,
   output logic [bb3_pkg::TOTAL_BITS-1:0]    total
);

   import bb3_pkg::*;

   localparam int RESET_W     = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
   localparam int TOTAL_RESET = RESET_W * 480;

   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic                   reg_sel;

   function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [WIDTH_BITS-1:0] w);
      logic [WIDTH_BITS-1:0] r;
      if (w == '0) begin
         r = WIDTH_BITS'(1);
      end else if (32'(w) > MAX_WIDTH) begin
         r = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         r = w;
      end
      return r;
   endfunction

   function automatic logic [HEIGHT_BITS-1:0] clamp_height(input logic [HEIGHT_BITS-1:0] h);
      return (h == '0) ? HEIGHT_BITS'(1) : h;
   endfunction

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign cfg_wr  = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_wr) begin
         case (reg_sel)
            CSR_IMAGE_WIDTH: begin
               width_in = pwdata[WIDTH_BITS-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = pwdata[HEIGHT_BITS-1:0];
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
      total_in = TOTAL_BITS'(clamp_width(width_in)) * TOTAL_BITS'(clamp_height(height_in));
   end

   always_comb begin
      case (reg_sel)
         CSR_IMAGE_WIDTH: begin
            prdata = DATA_BITS'(width_ff);
         end
         CSR_IMAGE_HEIGHT: begin
            prdata = DATA_BITS'(height_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         total_ff  <= TOTAL_BITS'(TOTAL_RESET);
      end else if (cfg_wr) begin
         width_ff  <= width_in;
         height_ff <= height_in;
         total_ff  <= total_in;
      end
   end

   assign width_eff  = clamp_width(width_ff);
   assign height_eff = clamp_height(height_ff);
   assign total      = total_ff;

endmodule

// File: src/bb3_seq.sv
// ----------------------------------------------------------------------------
// Box blur sequencer
// Raster counters, item filtering, border masks and the input stage register.
// ----------------------------------------------------------------------------
module bb3_seq #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cfg_wr,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [bb3_pkg::CHAN_BITS-1:0]    req_red_in,
   input  logic [bb3_pkg::CHAN_BITS-1:0]    req_green_in,
   input  logic [bb3_pkg::CHAN_BITS-1:0]    req_blue_in,
   input  logic [bb3_pkg::WIDTH_BITS-1:0]   width_eff,
   input  logic [bb3_pkg::HEIGHT_BITS-1:0]  height_eff,
   input  logic [bb3_pkg::TOTAL_BITS-1:0]   total,
   input  logic                             s2_free,
   input  bb3_pkg::pixel_type               mid_old,
   output logic                             rd_en,
   output logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
   output logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
   output logic                             s1_valid,
   output logic                             s1_adv,
   output bb3_pkg::step_type                step
);

   import bb3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic [CW-1:0]         col_ff, col_in;
   logic [CW-1:0]         s1_col_ff, s1_col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [TOTAL_BITS-1:0] cnt_ff, cnt_in;
   logic                  s1_valid_ff, s1_valid_in;
   step_type              step_ff, step_in;
   logic                  at_col0;
   logic                  keep;
   logic                  emit;
   logic                  last;
   logic                  accept;
   logic                  take;
   logic                  adv;

   always_comb begin
      at_col0 = (col_ff == '0);
      if (req_cmd == CMD_DRAIN) begin
         keep = 32'(pos_ff) >= 32'(total);
      end else begin
         keep = 32'(pos_ff) < 32'(total);
      end
      emit   = 32'(pos_ff) >= 32'(width_eff) + 32'd1;
      last   = emit && (32'(cnt_ff) + 32'd1 >= 32'(total));
      adv    = s1_valid_ff && s2_free;
      accept = req_valid && (!s1_valid_ff || s2_free);
      take   = accept && keep;

      col_in    = col_ff;
      row_in    = row_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      step_in   = step_ff;
      s1_col_in = s1_col_ff;

      if (take) begin
         step_in.emit  = emit;
         step_in.up    = at_col0 ? (32'(row_ff) >= 32'd3) : (32'(row_ff) >= 32'd2);
         step_in.down  = at_col0 ? (32'(row_ff) <= 32'(height_eff))
                                 : (32'(row_ff) < 32'(height_eff));
         step_in.left  = at_col0 ? (32'(width_eff) >= 32'd2) : (32'(col_ff) >= 32'd2);
         step_in.right = !at_col0;
         step_in.last  = last;
         step_in.fwd   = adv && (s1_col_ff == col_ff);
         step_in.pixel = {req_red_in, req_green_in, req_blue_in};
         step_in.fwd_up  = mid_old;
         step_in.fwd_mid = step_ff.pixel;
         s1_col_in = col_ff;

         if (last) begin
            col_in = '0;
            row_in = '0;
            pos_in = '0;
            cnt_in = '0;
         end else begin
            if (32'(col_ff) + 32'd1 >= 32'(width_eff)) begin
               col_in = '0;
               row_in = row_ff + ROW_BITS'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
            pos_in = pos_ff + POS_BITS'(1);
            cnt_in = cnt_ff + TOTAL_BITS'(emit);
         end
      end

      if (cfg_wr) begin
         col_in = '0;
         row_in = '0;
         pos_in = '0;
         cnt_in = '0;
      end

      if (take) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         pos_ff      <= '0;
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         pos_ff      <= pos_in;
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
      end
      step_ff   <= step_in;
      s1_col_ff <= s1_col_in;
   end

   assign req_ready = !s1_valid_ff || s2_free;
   assign rd_en     = take;
   assign rd_addr   = col_ff;
   assign wr_addr   = s1_col_ff;
   assign s1_valid  = s1_valid_ff;
   assign s1_adv    = adv;
   assign step      = step_ff;

endmodule

// File: src/bb3_window.sv
// ----------------------------------------------------------------------------
// Box blur window stage
// Shifts the 3x3 window and forms the masked per-channel sums and count.
// ----------------------------------------------------------------------------
module bb3_window (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cfg_wr,
   input  logic                                s1_adv,
   input  bb3_pkg::step_type                   step,
   input  logic [2*bb3_pkg::PIX_BITS-1:0]      ram_rd,
   input  logic                                out_free,
   output bb3_pkg::pixel_type                  mid_old,
   output logic                                s2_valid,
   output logic                                s2_free,
   output bb3_pkg::sums_type                   sums
);

   import bb3_pkg::*;

   localparam int ROW_SUM_BITS = CHAN_BITS + 2;

   pixel_type                win_ff [3][3];
   pixel_type                win_in [3][3];
   pixel_type                new_col [3];
   pixel_type                up_old;
   logic                     row_on [3];
   logic [ROW_SUM_BITS-1:0]  row_sum;
   logic [SUM_BITS-1:0]      sum_c [3];
   logic [1:0]               rows;
   logic [1:0]               cols;
   logic                     s2_valid_ff, s2_valid_in;
   sums_type                 sums_ff, sums_in;

   always_comb begin
      up_old  = step.fwd ? step.fwd_up : ram_rd[2*PIX_BITS-1:PIX_BITS];
      mid_old = step.fwd ? step.fwd_mid : ram_rd[PIX_BITS-1:0];
      new_col[0] = up_old;
      new_col[1] = mid_old;
      new_col[2] = step.pixel;
      row_on[0] = step.up;
      row_on[1] = 1'b1;
      row_on[2] = step.down;

      for (int ch = 0; ch < 3; ch++) begin
         sum_c[ch] = '0;
         for (int r = 0; r < 3; r++) begin
            row_sum = ROW_SUM_BITS'(win_ff[r][2][(2-ch)*CHAN_BITS +: CHAN_BITS]);
            if (step.left) begin
               row_sum = row_sum
                       + ROW_SUM_BITS'(win_ff[r][1][(2-ch)*CHAN_BITS +: CHAN_BITS]);
            end
            if (step.right) begin
               row_sum = row_sum
                       + ROW_SUM_BITS'(new_col[r][(2-ch)*CHAN_BITS +: CHAN_BITS]);
            end
            if (row_on[r]) begin
               sum_c[ch] = sum_c[ch] + SUM_BITS'(row_sum);
            end
         end
      end

      rows = 2'd1 + 2'(step.up) + 2'(step.down);
      cols = 2'd1 + 2'(step.left) + 2'(step.right);

      sums_in = sums_ff;
      if (s1_adv && step.emit) begin
         sums_in.red   = sum_c[0];
         sums_in.green = sum_c[1];
         sums_in.blue  = sum_c[2];
         sums_in.cnt   = CNT_BITS'(rows) * CNT_BITS'(cols);
         sums_in.last  = step.last;
      end

      if (s1_adv && step.emit) begin
         s2_valid_in = 1'b1;
      end else if (out_free) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end

      win_in = win_ff;
      if (s1_adv) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
            win_in[r][2] = new_col[r];
         end
         if (step.last) begin
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  win_in[r][c] = '0;
               end
            end
         end
      end
      if (cfg_wr) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_in[r][c] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         s2_valid_ff <= s2_valid_in;
         win_ff      <= win_in;
      end
      sums_ff <= sums_in;
   end

   assign s2_valid = s2_valid_ff;
   assign s2_free  = !s2_valid_ff || out_free;
   assign sums     = sums_ff;

endmodule

// File: src/bb3_mean.sv
// ----------------------------------------------------------------------------
// Box blur mean stage
// Rounds each channel sum to its mean by reciprocal multiply; output register.
// ----------------------------------------------------------------------------
module bb3_mean (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           s2_valid,
   input  bb3_pkg::sums_type              sums,
   input  logic                           rsp_ready,
   output logic                           out_free,
   output logic                           rsp_valid,
   output logic [bb3_pkg::CHAN_BITS-1:0]  rsp_red_out,
   output logic [bb3_pkg::CHAN_BITS-1:0]  rsp_green_out,
   output logic [bb3_pkg::CHAN_BITS-1:0]  rsp_blue_out,
   output logic                           rsp_frame_end
);

   import bb3_pkg::*;

   localparam int V_BITS    = SUM_BITS + 1;
   localparam int PROD_BITS = V_BITS + RECIP_BITS;

   logic [RECIP_BITS-1:0] m;
   logic [SUM_BITS-1:0]   sum_c [3];
   logic [V_BITS-1:0]     v;
   logic [PROD_BITS-1:0]  prod;
   logic [CHAN_BITS-1:0]  mean_c [3];
   logic                  load;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAN_BITS-1:0]  red_ff, red_in;
   logic [CHAN_BITS-1:0]  green_ff, green_in;
   logic [CHAN_BITS-1:0]  blue_ff, blue_in;
   logic                  last_ff, last_in;

   always_comb begin
      out_free = !out_valid_ff || rsp_ready;
      load     = s2_valid && out_free;
      m        = recip(sums.cnt);
      sum_c[0] = sums.red;
      sum_c[1] = sums.green;
      sum_c[2] = sums.blue;

      for (int ch = 0; ch < 3; ch++) begin
         v          = (V_BITS'(sum_c[ch]) << 1) + V_BITS'(sums.cnt);
         prod       = PROD_BITS'(v) * PROD_BITS'(m);
         mean_c[ch] = prod[RECIP_SHIFT +: CHAN_BITS];
      end

      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      last_in  = last_ff;
      if (load) begin
         red_in   = mean_c[0];
         green_in = mean_c[1];
         blue_in  = mean_c[2];
         last_in  = sums.last;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_frame_end = last_ff;

endmodule

// File: src/box_blur_3x3_clipped.sv
// ----------------------------------------------------------------------------
// Clipped 3x3 box blur: one item per clock cycle while the result side does not stall.
// A result passes the input stage, window sums and output registers before rsp_valid.
// Reset zeroes the raster counters and window and sets the size to 640 x 480.
// The line buffers are not cleared; their entries are written before use.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_clipped_defines.svh"

module box_blur_3x3_clipped #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bb3_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [bb3_pkg::DATA_BITS-1:0]     pwdata,
   output logic [bb3_pkg::DATA_BITS-1:0]     prdata,
   output logic                              pready,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [bb3_pkg::CHAN_BITS-1:0]     req_red_in,
   input  logic [bb3_pkg::CHAN_BITS-1:0]     req_green_in,
   input  logic [bb3_pkg::CHAN_BITS-1:0]     req_blue_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bb3_pkg::CHAN_BITS-1:0]     rsp_red_out,
   output logic [bb3_pkg::CHAN_BITS-1:0]     rsp_green_out,
   output logic [bb3_pkg::CHAN_BITS-1:0]     rsp_blue_out,
   output logic                              rsp_frame_end
);

   import bb3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic                     cfg_wr;
   logic [WIDTH_BITS-1:0]    width_eff;
   logic [HEIGHT_BITS-1:0]   height_eff;
   logic [TOTAL_BITS-1:0]    total;
   logic                     s1_valid;
   logic                     s1_adv;
   step_type                 s1_step;
   logic                     rd_en;
   logic [CW-1:0]            rd_addr;
   logic [CW-1:0]            wr_addr;
   pixel_type                mid_old;
   logic [2*PIX_BITS-1:0]    ram_rd;
   logic                     s2_valid;
   logic                     s2_free;
   sums_type                 s2_sums;
   logic                     out_free;

   bb3_csr #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg_wr     (cfg_wr),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .total      (total)
   );

   bb3_seq #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg_wr       (cfg_wr),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .width_eff    (width_eff),
      .height_eff   (height_eff),
      .total        (total),
      .s2_free      (s2_free),
      .mid_old      (mid_old),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .s1_valid     (s1_valid),
      .s1_adv       (s1_adv),
      .step         (s1_step)
   );

   bb3_ram #(
      .WIDTH (2 * PIX_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (wr_addr),
      .wr_data ({mid_old, s1_step.pixel}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   bb3_window u_window (
      .clock    (clock),
      .reset    (reset),
      .cfg_wr   (cfg_wr),
      .s1_adv   (s1_adv),
      .step     (s1_step),
      .ram_rd   (ram_rd),
      .out_free (out_free),
      .mid_old  (mid_old),
      .s2_valid (s2_valid),
      .s2_free  (s2_free),
      .sums     (s2_sums)
   );

   bb3_mean u_mean (
      .clock         (clock),
      .reset         (reset),
      .s2_valid      (s2_valid),
      .sums          (s2_sums),
      .rsp_ready     (rsp_ready),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

   `BB3_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !s1_valid, req_ready, "stalled while empty")
   `BB3_ASSERT_IMPLY(a_legal_count, clock, reset, s2_valid, s2_sums.cnt == CNT_BITS'(1) || s2_sums.cnt == CNT_BITS'(2) || s2_sums.cnt == CNT_BITS'(3) || s2_sums.cnt == CNT_BITS'(4) || s2_sums.cnt == CNT_BITS'(6) || s2_sums.cnt == CNT_BITS'(9), "neighborhood count out of range")
   `BB3_ASSERT_IMPLY(a_last_emits, clock, reset, s1_valid && s1_step.last, s1_step.emit, "frame end on an item without a result")
   `BB3_ASSERT_NEXT(a_stage_drains, clock, reset, s1_adv && !req_valid, !s1_valid, "input stage kept an item it passed on")

endmodule

// File: tb/sv/box_blur_3x3_clipped_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur 3x3 clipped regression bench
// Streams RGB frames of many sizes through the blur, including degenerate and
// extreme sizes, abandoned frames, stray drains and pixels past the image end.
// A built-in line-buffer predictor forms each expected mean, and every result
// item is compared field by field while both channels stall at random.
// ----------------------------------------------------------------------------
module box_blur_3x3_clipped_tb;
   import bb3_pkg::*;

   localparam int LINE_DEPTH    = 1024;
   localparam int IDLE_PCT      = 27;
   localparam int RANDOM_ITEMS  = 220;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 40;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
      logic                 frame_end;
   } blur_result_type;

   localparam pixel_type CORNER_PIXELS [9] = '{
      24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'hFFFFFF,
      24'h010101, 24'hFEFEFE, 24'h000000, 24'hFFFFFF
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [ADDR_BITS-1:0]  paddr = '0;
   logic [DATA_BITS-1:0]  pwdata = '0;
   logic [DATA_BITS-1:0]  prdata;
   logic                  pready;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_cmd = CMD_PIXEL;
   logic [CHAN_BITS-1:0]  req_red_in = '0;
   logic [CHAN_BITS-1:0]  req_green_in = '0;
   logic [CHAN_BITS-1:0]  req_blue_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHAN_BITS-1:0]  rsp_red_out;
   logic [CHAN_BITS-1:0]  rsp_green_out;
   logic [CHAN_BITS-1:0]  rsp_blue_out;
   logic                  rsp_frame_end;

   // Predictor state of the blur.
   pixel_type          upper_row [LINE_DEPTH];
   pixel_type          middle_row [LINE_DEPTH];
   pixel_type          blur_window [9];
   int unsigned        next_col = 0;
   int unsigned        next_row = 0;
   int unsigned        pixels_out = 0;
   logic [WIDTH_BITS-1:0]  cfg_width = WIDTH_RESET;
   logic [HEIGHT_BITS-1:0] cfg_height = HEIGHT_RESET;

   blur_result_type    expected_pixels [$];
   int                 mismatch_count = 0;
   int unsigned        cycle_count = 0;
   int                 items_taken = 0;
   int                 send_idle_pct = IDLE_PCT;
   int                 recv_idle_pct = IDLE_PCT;
   int                 recv_hold_left = 0;

   box_blur_3x3_clipped #(.MAX_WIDTH(LINE_DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("box_blur_3x3_clipped regression: fail");
         $finish;
      end
   end

   // The receiver can be told to hold off for a counted stretch of cycles.
   always @(negedge clock) begin
      if (recv_hold_left > 0) begin
         rsp_ready <= 1'b0;
         recv_hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic int unsigned active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
      return cfg_width;
   endfunction

   function automatic int unsigned active_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic void restart_frame();
      next_col = 0;
      next_row = 0;
      pixels_out = 0;
      foreach (blur_window[k]) blur_window[k] = '0;
   endfunction

   function automatic blur_result_type window_mean(input int centre, input bit up,
                                                   input bit down, input bit left,
                                                   input bit right);
      int unsigned sum_r, sum_g, sum_b, count;
      int          c;
      pixel_type   px;
      blur_result_type m;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      count = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         if ((dr < 0 && !up) || (dr > 0 && !down)) continue;
         for (int dc = -1; dc <= 1; dc++) begin
            if ((dc < 0 && !left) || (dc > 0 && !right)) continue;
            c = centre + dc;
            if (c < 0 || c > 2) continue;
            px = blur_window[(1 + dr) * 3 + c];
            sum_r += px[23:16];
            sum_g += px[15:8];
            sum_b += px[7:0];
            count++;
         end
      end
      m.red = CHAN_BITS'((2 * sum_r + count) / (2 * count));
      m.green = CHAN_BITS'((2 * sum_g + count) / (2 * count));
      m.blue = CHAN_BITS'((2 * sum_b + count) / (2 * count));
      m.frame_end = 1'b0;
      return m;
   endfunction

   // Advances the predictor by one accepted item; returns 1 when it yields a result.
   function automatic bit blur_step(input logic cmd, input pixel_type pix,
                                    output blur_result_type res, output bit taken);
      int unsigned w, h, total, col, row, pos;
      pixel_type   pixel, up_old, mid_old;
      bit          emitted;
      w = active_width();
      h = active_height();
      total = w * h;
      col = next_col;
      row = next_row;
      pos = row * w + col;
      emitted = 1'b0;
      res = '0;
      pixel = '0;
      taken = 1'b0;
      if (cmd == CMD_PIXEL) begin
         if (pos >= total) return 1'b0;
         pixel = pix;
      end else if (pos < total) begin
         return 1'b0;
      end
      taken = 1'b1;
      if (col == 0 && pos >= w + 1) begin
         res = window_mean(2, row >= 3, row - 1 < h, w >= 2, 1'b0);
         emitted = 1'b1;
      end
      up_old = upper_row[col];
      mid_old = middle_row[col];
      upper_row[col] = mid_old;
      middle_row[col] = pixel;
      for (int k = 0; k < 3; k++) begin
         blur_window[k * 3] = blur_window[k * 3 + 1];
         blur_window[k * 3 + 1] = blur_window[k * 3 + 2];
      end
      blur_window[2] = up_old;
      blur_window[5] = mid_old;
      blur_window[8] = pixel;
      if (col >= 1 && pos >= w + 1) begin
         res = window_mean(1, row >= 2, row < h, col >= 2, 1'b1);
         emitted = 1'b1;
      end
      next_col++;
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (!emitted) return 1'b0;
      pixels_out++;
      res.frame_end = (pixels_out >= total);
      if (res.frame_end) restart_frame();
      return 1'b1;
   endfunction

   function automatic logic [ADDR_BITS-1:0] reg_address(input logic index);
      return ADDR_BITS'(4 * int'(index));
   endfunction

   function automatic pixel_type random_pixel();
      case ($urandom_range(9))
         0: begin
            return '1;
         end
         1: begin
            return '0;
         end
         default: begin
            return pixel_type'($urandom);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
                  what, got, want, cycle_count);
   endtask

   always @(posedge clock) begin
      blur_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("result item with none expected", 1, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_red_out !== want.red) report_mismatch("red_out", rsp_red_out, want.red);
            if (rsp_green_out !== want.green)
               report_mismatch("green_out", rsp_green_out, want.green);
            if (rsp_blue_out !== want.blue)
               report_mismatch("blue_out", rsp_blue_out, want.blue);
            if (rsp_frame_end !== want.frame_end)
               report_mismatch("frame_end", rsp_frame_end, want.frame_end);
         end
      end
   end

   task automatic send_item(input logic cmd, input pixel_type pix);
      blur_result_type result;
      bit              produced, taken;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_red_in <= pix[23:16];
      req_green_in <= pix[15:8];
      req_blue_in <= pix[7:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = blur_step(cmd, pix, result, taken);
      if (produced) expected_pixels.push_back(result);
      if (taken) items_taken++;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [DATA_BITS-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= reg_address(index);
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (index == CSR_IMAGE_WIDTH) cfg_width = value[WIDTH_BITS-1:0];
      else cfg_height = value[HEIGHT_BITS-1:0];
      restart_frame();
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_register(input logic index, input int unsigned want, input int bits);
      logic [DATA_BITS-1:0] mask;
      mask = (DATA_BITS'(1) << bits) - 1;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= reg_address(index);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if ((prdata & mask) !== (DATA_BITS'(want) & mask))
         report_mismatch("register readback", prdata & mask, want);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_image_size(input int unsigned w, input int unsigned h);
      write_register(CSR_IMAGE_WIDTH, DATA_BITS'(w));
      write_register(CSR_IMAGE_HEIGHT, DATA_BITS'(h));
   endtask

   task automatic finish_frame();
      while (next_col != 0 || next_row != 0) send_item(CMD_DRAIN, random_pixel());
   endtask

   task automatic send_frame(input int abandon_at, input int noise_pct);
      int pixels;
      pixels = active_width() * active_height();
      for (int i = 0; i < pixels; i++) begin
         if (i == abandon_at) return;
         if ($urandom_range(99) < noise_pct) send_item(CMD_DRAIN, random_pixel());
         send_item(CMD_PIXEL, random_pixel());
      end
      if ($urandom_range(99) < noise_pct) send_item(CMD_PIXEL, random_pixel());
      finish_frame();
   endtask

   task automatic test_register_reset();
      check_register(CSR_IMAGE_WIDTH, WIDTH_RESET, WIDTH_BITS);
      check_register(CSR_IMAGE_HEIGHT, HEIGHT_RESET, HEIGHT_BITS);
   endtask

   // Part of a frame at the reset size; the next register write abandons it.
   task automatic test_abandoned_frame();
      for (int i = 0; i < 40; i++) begin
         if (i == 20) begin
            send_item(CMD_DRAIN, random_pixel());
            send_item(CMD_DRAIN, random_pixel());
         end
         send_item(CMD_PIXEL, random_pixel());
      end
      wait_quiet();
   endtask

   task automatic test_corner_values();
      set_image_size(3, 3);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_item(CMD_DRAIN, 24'hFFFFFF);
         send_item(CMD_PIXEL, CORNER_PIXELS[i]);
      end
      send_item(CMD_PIXEL, 24'h808080);
      finish_frame();
      wait_quiet();
      set_image_size(1, 1);
      send_item(CMD_PIXEL, 24'hFF01FE);
      finish_frame();
      wait_quiet();
      set_image_size(2, 2);
      send_item(CMD_PIXEL, 24'h010100);
      send_item(CMD_PIXEL, 24'h010000);
      send_item(CMD_PIXEL, 24'h000100);
      send_item(CMD_PIXEL, 24'hFFFFFF);
      finish_frame();
      wait_quiet();
   endtask

   task automatic test_degenerate_sizes();
      set_image_size(0, 3);
      send_frame(-1, 0);
      wait_quiet();
      set_image_size(5, 0);
      send_frame(-1, 0);
      wait_quiet();
   endtask

   task automatic test_extreme_sizes();
      set_image_size(1, 40);
      send_frame(-1, 0);
      wait_quiet();
   endtask

   // The receiver stops while the sender keeps offering, so the blur fills up.
   task automatic test_backpressure();
      set_image_size(12, 4);
      send_idle_pct = 0;
      recv_hold_left = HOLD_CYCLES;
      send_frame(-1, 0);
      send_idle_pct = IDLE_PCT;
      wait_quiet();
   endtask

   task automatic test_random_frames();
      int          frames;
      int          repeats;
      int unsigned w;
      bit          broken;
      frames = 0;
      items_taken = 0;
      while (items_taken < RANDOM_ITEMS) begin
         if (frames == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (frames == 4) begin
            send_idle_pct = IDLE_PCT;
            recv_idle_pct = IDLE_PCT;
         end
         wait_quiet();
         w = ($urandom_range(5) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
         set_image_size(w, $urandom_range(0, 6));
         repeats = $urandom_range(1, 3);
         for (int k = 0; k < repeats; k++) begin
            broken = ($urandom_range(9) == 0);
            if (broken) begin
               send_frame($urandom_range(active_width() * active_height() - 1), 8);
               break;
            end
            send_frame(-1, 8);
         end
         frames++;
      end
      wait_quiet();
   endtask

   initial begin
      restart_frame();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_register_reset();
      test_abandoned_frame();
      test_corner_values();
      test_degenerate_sizes();
      test_extreme_sizes();
      test_backpressure();
      test_random_frames();
      if (mismatch_count == 0) begin
         $display("box_blur_3x3_clipped regression: pass");
      end else begin
         $display("box_blur_3x3_clipped regression: fail");
      end
      $finish;
   end

endmodule
